// ----- sv/fpa_pkg.sv -----
// Fixed-point ALU package: word types, operation codes and sizing constants.
// Used by every module of the fixed_point_alu block.
`default_nettype none

package fpa_pkg;

	localparam int DATA_W       = 32;
	localparam int MODE_W       = 4;
	localparam int FRACTION_DEF = 8;

	localparam logic [MODE_W-1:0] MODE_ADD      = 4'd0;
	localparam logic [MODE_W-1:0] MODE_SUB      = 4'd1;
	localparam logic [MODE_W-1:0] MODE_MUL      = 4'd2;
	localparam logic [MODE_W-1:0] MODE_DIV      = 4'd3;
	localparam logic [MODE_W-1:0] MODE_MIN      = 4'd4;
	localparam logic [MODE_W-1:0] MODE_MAX      = 4'd5;
	localparam logic [MODE_W-1:0] MODE_INC      = 4'd6;
	localparam logic [MODE_W-1:0] MODE_DEC      = 4'd7;
	localparam logic [MODE_W-1:0] MODE_FROM_INT = 4'd8;
	localparam logic [MODE_W-1:0] MODE_TO_INT   = 4'd9;

	typedef struct packed {
		logic [MODE_W-1:0]        mode;
		logic signed [DATA_W-1:0] operand_a;
		logic signed [DATA_W-1:0] operand_b;
	} in_word_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic                     a_less;
		logic                     a_equal;
		logic                     a_greater;
		logic                     divide_by_zero;
	} out_word_t;

	typedef struct packed {
		logic [DATA_W-1:0] value;
		logic              a_less;
		logic              a_equal;
		logic              a_greater;
		logic              is_div;
		logic              negate;
		logic              div_zero;
	} side_t;

endpackage

`default_nettype wire

// ----- sv/fpa_div_step.sv -----
// One restoring-division stage: one quotient bit per register stage.
// Depends on fpa_pkg for the data width.
`default_nettype none

module fpa_div_step #(
	parameter int DQ_W = 40
) (
	input  wire                          clk,
	input  wire                          en,
	input  wire  [fpa_pkg::DATA_W-1:0]   rem_in,
	input  wire  [DQ_W-1:0]              dq_in,
	input  wire  [fpa_pkg::DATA_W-1:0]   dvs_in,
	output logic [fpa_pkg::DATA_W-1:0]   rem_out,
	output logic [DQ_W-1:0]              dq_out,
	output logic [fpa_pkg::DATA_W-1:0]   dvs_out
);
	import fpa_pkg::*;

	logic [DATA_W:0]   trial;
	logic [DATA_W:0]   diff;
	logic              qbit;
	logic [DATA_W-1:0] rem_next;

	always_comb begin
		trial    = {rem_in, dq_in[DQ_W-1]};
		diff     = trial - {1'b0, dvs_in};
		qbit     = ~diff[DATA_W];
		rem_next = qbit ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_out <= rem_next;
			dq_out  <= {dq_in[DQ_W-2:0], qbit};
			dvs_out <= dvs_in;
		end
	end

endmodule

`default_nettype wire

// ----- sv/fixed_point_alu.sv -----
// Fixed-point ALU top level: operand stage, decode/multiply stage,
// one divider stage per quotient bit, output register. Uses fpa_pkg, fpa_div_step.
// Every mode passes through all stages alike, including the bit-per-stage divider.
// Throughput: one word per cycle; a stall at the result holds the whole pipeline.
// Reset clears the valid bits only; the pipeline is empty after reset.
`default_nettype none

module fixed_point_alu #(
	parameter int FRACTION_BITS = fpa_pkg::FRACTION_DEF
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 op_valid,
	output logic                op_ready,
	input  wire fpa_pkg::in_word_t op,
	output logic                res_valid,
	input  wire                 res_ready,
	output fpa_pkg::out_word_t  res
);
	import fpa_pkg::*;

	localparam int DQ_W = DATA_W + FRACTION_BITS;

	logic                     en;
	logic                     vld_s1;
	in_word_t                 op_s1;
	logic                     vld_s2;
	in_word_t                 op_s2;
	logic signed [2*DATA_W-1:0] prod_s2;
	logic [DATA_W-1:0]        abs_a;
	logic [DATA_W-1:0]        abs_b;
	side_t                    side_in;
	logic signed [2*DATA_W-1:0] prod_sh;
	logic signed [DATA_W-1:0] a2;
	logic signed [DATA_W-1:0] b2;

	logic [DATA_W-1:0] rem_d [DQ_W+1];
	logic [DQ_W-1:0]   dq_d  [DQ_W+1];
	logic [DATA_W-1:0] dvs_d [DQ_W+1];
	side_t             side_d [DQ_W+1];
	logic [DQ_W:0]     vld_d;

	logic [DATA_W-1:0] quo;
	out_word_t         res_next;

	assign en       = ~res_valid | res_ready;
	assign op_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= op_valid;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1   <= op;
			op_s2   <= op_s1;
			prod_s2 <= op_s1.operand_a * op_s1.operand_b;
		end
	end

	always_comb begin
		a2      = op_s2.operand_a;
		b2      = op_s2.operand_b;
		abs_a   = a2[DATA_W-1] ? DATA_W'(-a2) : DATA_W'(a2);
		abs_b   = b2[DATA_W-1] ? DATA_W'(-b2) : DATA_W'(b2);
		prod_sh = prod_s2 >>> FRACTION_BITS;
		side_in = '0;
		side_in.a_less    = a2 < b2;
		side_in.a_equal   = a2 == b2;
		side_in.a_greater = a2 > b2;
		side_in.is_div    = op_s2.mode == MODE_DIV;
		side_in.negate    = a2[DATA_W-1] ^ b2[DATA_W-1];
		side_in.div_zero  = (op_s2.mode == MODE_DIV) && (b2 == '0);
		case (op_s2.mode)
			MODE_ADD:      side_in.value = a2 + b2;
			MODE_SUB:      side_in.value = a2 - b2;
			MODE_MUL:      side_in.value = prod_sh[DATA_W-1:0];
			MODE_MIN:      side_in.value = (a2 < b2) ? a2 : b2;
			MODE_MAX:      side_in.value = (a2 > b2) ? a2 : b2;
			MODE_INC:      side_in.value = a2 + DATA_W'(1);
			MODE_DEC:      side_in.value = a2 - DATA_W'(1);
			MODE_FROM_INT: side_in.value = a2 << FRACTION_BITS;
			MODE_TO_INT:   side_in.value = a2 >>> FRACTION_BITS;
			default:       side_in.value = '0;
		endcase
	end

	assign rem_d[0]  = '0;
	assign dq_d[0]   = DQ_W'(abs_a) << FRACTION_BITS;
	assign dvs_d[0]  = abs_b;
	assign side_d[0] = side_in;
	assign vld_d[0]  = vld_s2;

	for (genvar k = 0; k < DQ_W; k++) begin : g_div
		fpa_div_step #(
			.DQ_W (DQ_W)
		) u_step (
			.clk     (clk),
			.en      (en),
			.rem_in  (rem_d[k]),
			.dq_in   (dq_d[k]),
			.dvs_in  (dvs_d[k]),
			.rem_out (rem_d[k+1]),
			.dq_out  (dq_d[k+1]),
			.dvs_out (dvs_d[k+1])
		);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_d[k+1] <= 1'b0;
			end else if (en) begin
				vld_d[k+1] <= vld_d[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_d[k+1] <= side_d[k];
			end
		end
	end

	always_comb begin
		quo = dq_d[DQ_W][DATA_W-1:0];
		res_next.a_less         = side_d[DQ_W].a_less;
		res_next.a_equal        = side_d[DQ_W].a_equal;
		res_next.a_greater      = side_d[DQ_W].a_greater;
		res_next.divide_by_zero = side_d[DQ_W].div_zero;
		if (side_d[DQ_W].div_zero) begin
			res_next.value = '0;
		end else if (side_d[DQ_W].is_div) begin
			res_next.value = side_d[DQ_W].negate ? -quo : quo;
		end else begin
			res_next.value = side_d[DQ_W].value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (en) begin
			res_valid <= vld_d[DQ_W];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res <= res_next;
		end
	end

endmodule

`default_nettype wire
